>>> rtl/rect_fill_alpha_over_defines.svh
// Assertion macros for the rectangle fill block (clock and reset named clock and reset).
`ifndef RECT_FILL_ALPHA_OVER_DEFINES_SVH
`define RECT_FILL_ALPHA_OVER_DEFINES_SVH

// same-cycle implication
`define RFAO_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rect_fill_alpha_over: check failed");

// consequent checked a fixed number of cycles later
`define RFAO_ASSERT_DELAY(label, ante, cons, dly) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error("rect_fill_alpha_over: check failed");

`endif

>>> rtl/rfao_pkg.sv
// Shared constants, types and arithmetic helpers for the rectangle fill block.
package rfao_pkg;

   localparam int DEF_MAX_DIM = 4096;
   localparam int DIM_W       = 13;
   localparam int COORD_W     = 16;
   localparam int PIX_W       = 12;
   localparam int CHAN_W      = 8;
   localparam int SUM_W       = 2 * CHAN_W;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int NUM_COLOR   = 3;

   localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_CORNER_AX    = 3'd2,
      CSR_CORNER_AY    = 3'd3,
      CSR_CORNER_BX    = 3'd4,
      CSR_CORNER_BY    = 3'd5,
      CSR_FILL_RGB     = 3'd6,
      CSR_FILL_ALPHA   = 3'd7
   } csr_index_type;

   // clamp a signed corner coordinate into [0, hi]
   function automatic logic [DIM_W-1:0] clamp_corner(input logic [COORD_W-1:0] v,
                                                     input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v[COORD_W-1]) begin
         r = '0;
      end else if (v[COORD_W-2:0] > {{(COORD_W-1-DIM_W){1'b0}}, hi}) begin
         r = hi;
      end else begin
         r = v[DIM_W-1:0];
      end
      return r;
   endfunction

   // floor(s / 255), exact for s <= 255*255
   function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] s);
      logic [SUM_W:0] t;
      t = {1'b0, s} + {{(CHAN_W+1){1'b0}}, s[SUM_W-1:CHAN_W]} + {{SUM_W{1'b0}}, 1'b1};
      return t[SUM_W-1:CHAN_W];
   endfunction

   function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] p,
                                                 input logic [CHAN_W-1:0] a);
      logic [CHAN_W:0] s;
      s = {1'b0, p} + {1'b0, a};
      return s[CHAN_W] ? CHAN_MAX : s[CHAN_W-1:0];
   endfunction

endpackage

>>> rtl/rect_fill_alpha_over.sv
// Streaming rectangle fill with alpha-over blending for 8-bit RGBA pixels.
//
// Requests: start with pixel coordinates and RGBA on the req_ ports; a request
// is taken at every clock edge with start high (busy is held low, the
// pipeline never stalls). One pixel per clock sustained.
// Responses: rsp_valid is high for one cycle and the result is taken from the
// stage 3 registers, in request order. No stall input.
// Stages: 1) corner clamp to the frame size, 2) corner ordering, inside test
// and per-channel 8x8 products, 3) divide by 255, alpha saturation, select.
// Configuration: csr_we/csr_index/csr_wdata write one register per clock;
// write only when no request is in flight.
// Reset (synchronous, active high) clears config and valid registers to 0 and
// drops in-flight requests; the fill stays disabled until fill_alpha is set.
`include "rect_fill_alpha_over_defines.svh"

module rect_fill_alpha_over #(
   parameter int MAX_DIM = rfao_pkg::DEF_MAX_DIM
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [rfao_pkg::PIX_W-1:0]          req_pixel_x,
   input  logic [rfao_pkg::PIX_W-1:0]          req_pixel_y,
   input  logic [rfao_pkg::CHAN_W-1:0]         req_in_red,
   input  logic [rfao_pkg::CHAN_W-1:0]         req_in_green,
   input  logic [rfao_pkg::CHAN_W-1:0]         req_in_blue,
   input  logic [rfao_pkg::CHAN_W-1:0]         req_in_alpha,
   output logic                                rsp_valid,
   output logic [rfao_pkg::CHAN_W-1:0]         rsp_out_red,
   output logic [rfao_pkg::CHAN_W-1:0]         rsp_out_green,
   output logic [rfao_pkg::CHAN_W-1:0]         rsp_out_blue,
   output logic [rfao_pkg::CHAN_W-1:0]         rsp_out_alpha,
   output logic                                rsp_was_filled,
   input  logic                                csr_we,
   input  logic [rfao_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rfao_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rfao_pkg::*;

   localparam int DIM_LIMIT = (1 << DIM_W) - 1;
   localparam int DIM_CAP   = (MAX_DIM > DIM_LIMIT) ? DIM_LIMIT : MAX_DIM;
   localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_CAP[DIM_W-1:0];

   // configuration registers
   logic [DIM_W-1:0]              frame_width_ff, frame_height_ff;
   logic [COORD_W-1:0]            corner_ax_ff, corner_ay_ff, corner_bx_ff, corner_by_ff;
   logic [NUM_COLOR*CHAN_W-1:0]   fill_rgb_ff;
   logic [CHAN_W-1:0]             fill_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
         corner_ax_ff    <= '0;
         corner_ay_ff    <= '0;
         corner_bx_ff    <= '0;
         corner_by_ff    <= '0;
         fill_rgb_ff     <= '0;
         fill_alpha_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_CORNER_AX:    corner_ax_ff    <= csr_wdata[COORD_W-1:0];
            CSR_CORNER_AY:    corner_ay_ff    <= csr_wdata[COORD_W-1:0];
            CSR_CORNER_BX:    corner_bx_ff    <= csr_wdata[COORD_W-1:0];
            CSR_CORNER_BY:    corner_by_ff    <= csr_wdata[COORD_W-1:0];
            CSR_FILL_RGB:     fill_rgb_ff     <= csr_wdata[NUM_COLOR*CHAN_W-1:0];
            CSR_FILL_ALPHA:   fill_alpha_ff   <= csr_wdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: clamp corners
   logic                          s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]              s1_px_ff, s1_py_ff;
   logic [NUM_COLOR-1:0][CHAN_W-1:0] s1_pix_ff, s1_pix_in;
   logic [CHAN_W-1:0]             s1_alpha_ff;
   logic [DIM_W-1:0]              s1_x1_ff, s1_x2_ff, s1_y1_ff, s1_y2_ff;
   logic [DIM_W-1:0]              s1_x1_in, s1_x2_in, s1_y1_in, s1_y2_in;
   logic [DIM_W-1:0]              w_lim, h_lim;

   always_comb begin
      w_lim       = (frame_width_ff  > DIM_CAP_V) ? DIM_CAP_V : frame_width_ff;
      h_lim       = (frame_height_ff > DIM_CAP_V) ? DIM_CAP_V : frame_height_ff;
      s1_x1_in    = clamp_corner(corner_ax_ff, w_lim);
      s1_x2_in    = clamp_corner(corner_bx_ff, w_lim);
      s1_y1_in    = clamp_corner(corner_ay_ff, h_lim);
      s1_y2_in    = clamp_corner(corner_by_ff, h_lim);
      s1_valid_in = start && !busy;
      s1_pix_in   = {req_in_blue, req_in_green, req_in_red};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_px_ff    <= req_pixel_x;
      s1_py_ff    <= req_pixel_y;
      s1_pix_ff   <= s1_pix_in;
      s1_alpha_ff <= req_in_alpha;
      s1_x1_ff    <= s1_x1_in;
      s1_x2_ff    <= s1_x2_in;
      s1_y1_ff    <= s1_y1_in;
      s1_y2_ff    <= s1_y2_in;
   end

   // stage 2: order corners, inside test, products
   logic                          s2_valid_ff, s2_inside_ff, s2_inside_in;
   logic [NUM_COLOR-1:0][SUM_W-1:0]  s2_sum_ff, s2_sum_in;
   logic [NUM_COLOR-1:0][CHAN_W-1:0] s2_pix_ff;
   logic [CHAN_W-1:0]             s2_alpha_ff;
   logic [DIM_W-1:0]              x_lo, x_hi, y_lo, y_hi, px_ext, py_ext;
   logic [CHAN_W-1:0]             inv_a;
   logic [SUM_W-1:0]              prod_c, prod_p;
   logic [SUM_W:0]                sum_full;

   always_comb begin
      x_lo   = (s1_x1_ff > s1_x2_ff) ? s1_x2_ff : s1_x1_ff;
      x_hi   = (s1_x1_ff > s1_x2_ff) ? s1_x1_ff : s1_x2_ff;
      y_lo   = (s1_y1_ff > s1_y2_ff) ? s1_y2_ff : s1_y1_ff;
      y_hi   = (s1_y1_ff > s1_y2_ff) ? s1_y1_ff : s1_y2_ff;
      px_ext = {{(DIM_W-PIX_W){1'b0}}, s1_px_ff};
      py_ext = {{(DIM_W-PIX_W){1'b0}}, s1_py_ff};
      s2_inside_in = (fill_alpha_ff != '0) && (px_ext >= x_lo) && (px_ext < x_hi)
                     && (py_ext >= y_lo) && (py_ext < y_hi);
      inv_a  = CHAN_MAX - fill_alpha_ff;
      prod_c = '0;
      prod_p = '0;
      sum_full = '0;
      for (int k = 0; k < NUM_COLOR; k++) begin
         prod_c = {{CHAN_W{1'b0}}, fill_rgb_ff[k*CHAN_W +: CHAN_W]}
                  * {{CHAN_W{1'b0}}, fill_alpha_ff};
         prod_p = {{CHAN_W{1'b0}}, s1_pix_ff[k]} * {{CHAN_W{1'b0}}, inv_a};
         sum_full = {1'b0, prod_c} + {1'b0, prod_p};
         s2_sum_in[k] = sum_full[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_inside_ff <= s2_inside_in;
      s2_sum_ff    <= s2_sum_in;
      s2_pix_ff    <= s1_pix_ff;
      s2_alpha_ff  <= s1_alpha_ff;
   end

   // stage 3: divide, saturate, select
   logic                          rsp_valid_ff, rsp_filled_ff;
   logic [NUM_COLOR-1:0][CHAN_W-1:0] rsp_color_ff, rsp_color_in;
   logic [CHAN_W-1:0]             rsp_alpha_ff, rsp_alpha_in;

   always_comb begin
      for (int k = 0; k < NUM_COLOR; k++) begin
         rsp_color_in[k] = s2_inside_ff ? div255(s2_sum_ff[k]) : s2_pix_ff[k];
      end
      rsp_alpha_in = s2_inside_ff ? sat_add(s2_alpha_ff, fill_alpha_ff) : s2_alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      rsp_filled_ff <= s2_inside_ff;
      rsp_color_ff  <= rsp_color_in;
      rsp_alpha_ff  <= rsp_alpha_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_color_ff[0];
   assign rsp_out_green  = rsp_color_ff[1];
   assign rsp_out_blue   = rsp_color_ff[2];
   assign rsp_out_alpha  = rsp_alpha_ff;
   assign rsp_was_filled = rsp_filled_ff;

   `RFAO_ASSERT_DELAY(a_latency, start && !busy, rsp_valid, 3)
   `RFAO_ASSERT_IMPLY(a_pass_red, rsp_valid && !rsp_was_filled,
                      rsp_out_red == $past(req_in_red, 3))
   `RFAO_ASSERT_IMPLY(a_alpha_grows, rsp_valid && rsp_was_filled,
                      rsp_out_alpha >= $past(req_in_alpha, 3) && fill_alpha_ff != '0)

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the rectangle fill stage with alpha-over blending.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rfao_pkg::*;

   localparam int MAX_SIDE    = 4096;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      logic [DIM_W-1:0]      width;
      logic [DIM_W-1:0]      height;
      logic [COORD_W-1:0]    ax;
      logic [COORD_W-1:0]    ay;
      logic [COORD_W-1:0]    bx;
      logic [COORD_W-1:0]    by;
      logic [CSR_DATA_W-1:0] rgb;
      logic [CHAN_W-1:0]     alpha;
   } fill_setup_type;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              filled;
   } pixel_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [PIX_W-1:0]      req_pixel_x;
   logic [PIX_W-1:0]      req_pixel_y;
   logic [CHAN_W-1:0]     req_in_red;
   logic [CHAN_W-1:0]     req_in_green;
   logic [CHAN_W-1:0]     req_in_blue;
   logic [CHAN_W-1:0]     req_in_alpha;
   logic                  rsp_valid;
   logic [CHAN_W-1:0]     rsp_out_red;
   logic [CHAN_W-1:0]     rsp_out_green;
   logic [CHAN_W-1:0]     rsp_out_blue;
   logic [CHAN_W-1:0]     rsp_out_alpha;
   logic                  rsp_was_filled;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fill_setup_type   setup;        // mirror of the block's registers
   pixel_result_type blended_q[$];
   int               mismatches;
   int               pixels_sent;
   int               pixels_filled;
   int               setups_applied;
   int               cycles;

   rect_fill_alpha_over u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .req_in_alpha   (req_in_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_alpha  (rsp_out_alpha),
      .rsp_was_filled (rsp_was_filled),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic int clamp_axis(input logic [COORD_W-1:0] raw, input int hi);
      int v;
      v = $signed(raw);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void rect_bounds(output int x_lo, output int x_hi,
                                       output int y_lo, output int y_hi,
                                       output int w, output int h);
      int x1, x2, y1, y2;
      w  = (setup.width  > MAX_SIDE) ? MAX_SIDE : int'(setup.width);
      h  = (setup.height > MAX_SIDE) ? MAX_SIDE : int'(setup.height);
      x1 = clamp_axis(setup.ax, w);
      x2 = clamp_axis(setup.bx, w);
      y1 = clamp_axis(setup.ay, h);
      y2 = clamp_axis(setup.by, h);
      x_lo = (x1 < x2) ? x1 : x2;
      x_hi = (x1 < x2) ? x2 : x1;
      y_lo = (y1 < y2) ? y1 : y2;
      y_hi = (y1 < y2) ? y2 : y1;
   endfunction

   function automatic logic [CHAN_W-1:0] blend_channel(input int c, input int p, input int a);
      return CHAN_W'((c * a + p * (255 - a)) / 255);
   endfunction

   function automatic pixel_result_type predict_pixel(input logic [PIX_W-1:0] x,
                                                      input logic [PIX_W-1:0] y,
                                                      input logic [CHAN_W-1:0] r,
                                                      input logic [CHAN_W-1:0] g,
                                                      input logic [CHAN_W-1:0] b,
                                                      input logic [CHAN_W-1:0] a);
      pixel_result_type res;
      int x_lo, x_hi, y_lo, y_hi, w, h, sum, fa;
      rect_bounds(x_lo, x_hi, y_lo, y_hi, w, h);
      fa = int'(setup.alpha);
      if (fa != 0 && int'(x) >= x_lo && int'(x) < x_hi && int'(y) >= y_lo && int'(y) < y_hi) begin
         sum        = int'(a) + fa;
         res.red    = blend_channel(int'(setup.rgb[7:0]), int'(r), fa);
         res.green  = blend_channel(int'(setup.rgb[15:8]), int'(g), fa);
         res.blue   = blend_channel(int'(setup.rgb[23:16]), int'(b), fa);
         res.alpha  = (sum > 255) ? 8'd255 : sum[7:0];
         res.filled = 1'b1;
      end else begin
         res.red    = r;
         res.green  = g;
         res.blue   = b;
         res.alpha  = a;
         res.filled = 1'b0;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < PRINT_LIMIT)
         $display("[%0t] error: %s got %0d want %0d", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : result_check
      pixel_result_type want;
      if (!reset && rsp_valid) begin
         if (blended_q.size() == 0) begin
            report_mismatch("result with no request pending", int'(rsp_out_red), 0);
         end else begin
            want = blended_q.pop_front();
            if (rsp_out_red !== want.red)
               report_mismatch("out_red", int'(rsp_out_red), int'(want.red));
            if (rsp_out_green !== want.green)
               report_mismatch("out_green", int'(rsp_out_green), int'(want.green));
            if (rsp_out_blue !== want.blue)
               report_mismatch("out_blue", int'(rsp_out_blue), int'(want.blue));
            if (rsp_out_alpha !== want.alpha)
               report_mismatch("out_alpha", int'(rsp_out_alpha), int'(want.alpha));
            if (rsp_was_filled !== want.filled)
               report_mismatch("was_filled", int'(rsp_was_filled), int'(want.filled));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                             input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a);
      pixel_result_type res;
      @(negedge clock);
      start        <= 1'b1;
      req_pixel_x  <= x;
      req_pixel_y  <= y;
      req_in_red   <= r;
      req_in_green <= g;
      req_in_blue  <= b;
      req_in_alpha <= a;
      @(posedge clock);
      while (busy) @(posedge clock);
      res = predict_pixel(x, y, r, g, b, a);
      blended_q.push_back(res);
      pixels_sent++;
      if (res.filled) pixels_filled++;
   endtask

   task automatic hold_off(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic wait_results();
      @(negedge clock);
      start <= 1'b0;
      while (blended_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      start     <= 1'b0;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // unused upper bits carry random junk
   task automatic apply_setup(input fill_setup_type s);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_FRAME_WIDTH,  {junk[23:13], s.width});
      write_reg(CSR_FRAME_HEIGHT, {junk[10:0], s.height});
      write_reg(CSR_CORNER_AX,    {junk[7:0], s.ax});
      write_reg(CSR_CORNER_AY,    {junk[15:8], s.ay});
      write_reg(CSR_CORNER_BX,    {junk[23:16], s.bx});
      write_reg(CSR_CORNER_BY,    {junk[19:12], s.by});
      write_reg(CSR_FILL_RGB,     s.rgb);
      write_reg(CSR_FILL_ALPHA,   {junk[15:0], s.alpha});
      setup = s;
      setups_applied++;
   endtask

   function automatic fill_setup_type make_setup(input int w, input int h, input int ax,
                                                 input int ay, input int bx, input int by,
                                                 input logic [CSR_DATA_W-1:0] rgb,
                                                 input logic [CHAN_W-1:0] alpha);
      fill_setup_type s;
      s.width  = DIM_W'(w);
      s.height = DIM_W'(h);
      s.ax     = COORD_W'(ax);
      s.ay     = COORD_W'(ay);
      s.bx     = COORD_W'(bx);
      s.by     = COORD_W'(by);
      s.rgb    = rgb;
      s.alpha  = alpha;
      return s;
   endfunction

   // ---------------------------------------------------------------- random helpers

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return 1;
      if (r < 18) return $urandom_range(2, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic int random_dim();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return MAX_SIDE;
         2: return $urandom_range(MAX_SIDE + 1, 8191);
         3: return 8191;
         4: return $urandom_range(1, 16);
         default: return $urandom_range(1, MAX_SIDE);
      endcase
   endfunction

   function automatic int random_corner(input int dim);
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2: return -int'($urandom_range(1, 32768));
         3: return dim + int'($urandom_range(0, 32767 - dim));
         default: return $urandom_range(0, dim);
      endcase
   endfunction

   function automatic fill_setup_type random_setup();
      int w, h, we, he;
      logic [CHAN_W-1:0] a;
      w  = random_dim();
      h  = random_dim();
      we = (w > MAX_SIDE) ? MAX_SIDE : w;
      he = (h > MAX_SIDE) ? MAX_SIDE : h;
      case ($urandom_range(0, 7))
         0: a = 8'd0;
         1: a = 8'd255;
         2: a = 8'd1;
         3: a = 8'd254;
         default: a = CHAN_W'($urandom_range(0, 255));
      endcase
      return make_setup(w, h, random_corner(we), random_corner(he),
                        random_corner(we), random_corner(he), CSR_DATA_W'($urandom), a);
   endfunction

   // half inside the rectangle, the rest often on its edges or the frame edge
   function automatic logic [PIX_W-1:0] pick_coord(input int lo, input int hi, input int dim);
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4:
            v = (hi > lo) ? int'($urandom_range(lo, hi - 1)) : int'($urandom_range(0, 4095));
         5: v = lo + int'($urandom_range(0, 2)) - 1;
         6: v = hi + int'($urandom_range(0, 2)) - 1;
         7: v = dim - int'($urandom_range(0, 1));
         8: v = $urandom_range(0, 1) ? 4095 : 0;
         default: v = $urandom_range(0, 4095);
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return PIX_W'(v);
   endfunction

   task automatic send_random_pixel();
      int x_lo, x_hi, y_lo, y_hi, w, h;
      logic [CHAN_W-1:0] a, r, g, b;
      rect_bounds(x_lo, x_hi, y_lo, y_hi, w, h);
      case ($urandom_range(0, 5))
         0: a = 8'd0;
         1: a = 8'd255;
         default: a = CHAN_W'($urandom_range(0, 255));
      endcase
      r = CHAN_W'($urandom_range(0, 255));
      g = CHAN_W'($urandom_range(0, 255));
      b = CHAN_W'($urandom_range(0, 255));
      send_pixel(pick_coord(x_lo, x_hi, w), pick_coord(y_lo, y_hi, h), r, g, b, a);
   endtask

   // ---------------------------------------------------------------- tests

   // registers at reset: zero alpha and an empty rectangle
   task automatic test_reset_passthrough();
      send_pixel(12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      wait_results();
   endtask

   task automatic test_full_frame_opaque();
      apply_setup(make_setup(4096, 4096, 0, 0, 4096, 4096, 24'h563412, 8'd255));
      send_pixel(12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(12'd2048, 12'd17, 8'h5A, 8'hA5, 8'h3C, 8'h80);
      wait_results();
   endtask

   task automatic test_zero_alpha();
      apply_setup(make_setup(4096, 4096, 0, 0, 4096, 4096, 24'hFFFFFF, 8'd0));
      send_pixel(12'd100, 12'd100, 8'h12, 8'h34, 8'h56, 8'h78);
      send_pixel(12'd0, 12'd0, 8'hFF, 8'h00, 8'hFF, 8'h00);
      wait_results();
   endtask

   task automatic test_swapped_corners();
      apply_setup(make_setup(200, 200, 100, 50, 10, 5, 24'hFFFFFF, 8'd1));
      send_pixel(12'd10, 12'd5, 8'h00, 8'h80, 8'hFF, 8'hFF);
      send_pixel(12'd99, 12'd49, 8'hFF, 8'h01, 8'hFE, 8'h00);
      send_pixel(12'd100, 12'd49, 8'h11, 8'h22, 8'h33, 8'h44);
      send_pixel(12'd9, 12'd5, 8'h55, 8'h66, 8'h77, 8'h88);
      send_pixel(12'd50, 12'd50, 8'h99, 8'hAA, 8'hBB, 8'hCC);
      wait_results();
   endtask

   task automatic test_empty_rect();
      apply_setup(make_setup(200, 200, 20, 0, 20, 100, 24'h00FF00, 8'd128));
      send_pixel(12'd20, 12'd10, 8'h10, 8'h20, 8'h30, 8'h40);
      send_pixel(12'd19, 12'd10, 8'h50, 8'h60, 8'h70, 8'h80);
      wait_results();
   endtask

   task automatic test_oversized_frame();
      apply_setup(make_setup(8191, 4097, -32768, -32768, 32767, 32767, 24'hABCDEF, 8'd200));
      send_pixel(12'hFFF, 12'd0, 8'h00, 8'hFF, 8'h7F, 8'h40);
      send_pixel(12'd0, 12'hFFF, 8'hFF, 8'h00, 8'h80, 8'hC0);
      send_pixel(12'hFFF, 12'hFFF, 8'h3C, 8'hC3, 8'h99, 8'h37);
      wait_results();
   endtask

   task automatic test_outside_frame();
      apply_setup(make_setup(100, 60, 0, 0, 32767, 32767, 24'h102030, 8'd77));
      send_pixel(12'd99, 12'd59, 8'h80, 8'h80, 8'h80, 8'hB3);
      send_pixel(12'd100, 12'd30, 8'h80, 8'h80, 8'h80, 8'h80);
      send_pixel(12'd30, 12'd60, 8'h80, 8'h80, 8'h80, 8'h80);
      send_pixel(12'hFFF, 12'hFFF, 8'h80, 8'h80, 8'h80, 8'h80);
      wait_results();
   endtask

   task automatic test_zero_frame();
      apply_setup(make_setup(0, 0, 0, 0, 50, 50, 24'hFFFFFF, 8'd255));
      send_pixel(12'd0, 12'd0, 8'h01, 8'h02, 8'h03, 8'h04);
      wait_results();
   endtask

   task automatic test_random_phases(input int total);
      int sent, n, phase_len, gap_mode, pause_at, phase;
      sent  = 0;
      phase = 0;
      while (sent < total) begin
         apply_setup(random_setup());
         phase_len = $urandom_range(20, 60);
         gap_mode  = $urandom_range(0, 3);
         if (phase == 0 || $urandom_range(0, 3) == 0)
            pause_at = $urandom_range(1, phase_len - 2);
         else
            pause_at = -1;
         for (n = 0; n < phase_len && sent < total; n++) begin
            send_random_pixel();
            sent++;
            if (n == pause_at)
               wait_results();
            else if (gap_mode != 0 && $urandom_range(0, 2) == 0)
               hold_off(random_gap());
         end
         wait_results();
         phase++;
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_pixel_x    = '0;
      req_pixel_y    = '0;
      req_in_red     = '0;
      req_in_green   = '0;
      req_in_blue    = '0;
      req_in_alpha   = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_FRAME_WIDTH;
      csr_wdata      = '0;
      mismatches     = 0;
      pixels_sent    = 0;
      pixels_filled  = 0;
      setups_applied = 0;
      cycles         = 0;
      setup          = make_setup(0, 0, 0, 0, 0, 0, '0, '0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_passthrough();
      test_full_frame_opaque();
      test_zero_alpha();
      test_swapped_corners();
      test_empty_rect();
      test_oversized_frame();
      test_outside_frame();
      test_zero_frame();
      test_random_phases(1530);

      wait_results();
      if (blended_q.size() != 0)
         report_mismatch("results never arrived", blended_q.size(), 0);
      $display("Covered %0d pixel requests (%0d blended) under %0d register settings,",
               pixels_sent, pixels_filled, setups_applied);
      $display("including clamped, swapped, empty and full-frame rectangles and zero alpha.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
